FILE: rtl/sample_history_ring_buffer_top_assert.svh
// Assertion macros shared by the sample history ring buffer modules.
`ifndef SAMPLE_HISTORY_RING_BUFFER_TOP_ASSERT_SVH
`define SAMPLE_HISTORY_RING_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SHRB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SHRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/shrb_pkg.sv
// Types, constants and defaults shared by the sample history ring buffer.
package shrb_pkg;

    localparam int CAPACITY_DEF    = 65536;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int TIME_W   = 48;
    localparam int POS_W    = 16;
    localparam int FLEN_W   = 13;
    localparam int SAMPLE_W = 32;
    localparam int DIFF_W   = TIME_W + 2;

    localparam int IN_TDATA_W  = SAMPLE_W + TIME_W + TIME_W + POS_W;
    localparam int OUT_TDATA_W = SAMPLE_W + POS_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [FLEN_W-1:0] FLEN_RESET = FLEN_W'(1024);
    localparam logic              REG_FRAME_LENGTH = 1'b0;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Remainder unit: quotient bits resolved per cycle, and cycles per item.
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = POS_W / DIV_BITS_PER_CYCLE;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_OFFS,
        ST_ADDR,
        ST_DATA,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic store;
        logic calc_diff;
        logic calc_offs;
        logic rd_en;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/shrb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module shrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/shrb_frame_div.sv
// Iterative remainder unit: read position modulo frame length, DIV_BITS_PER_CYCLE bits per cycle while step is high.
module shrb_frame_div import shrb_pkg::*; (
    input  logic              clk,
    input  logic              start,
    input  logic              step,
    input  logic [POS_W-1:0]  dividend,
    input  logic [FLEN_W-1:0] divisor,
    output logic [FLEN_W-1:0] remainder
);

    logic [POS_W-1:0]  shift_reg, shift_next;
    logic [FLEN_W-1:0] rem_reg, rem_next;
    logic [FLEN_W-1:0] div_reg;

    always_comb
    begin
        logic [FLEN_W:0]   trial;
        logic [FLEN_W-1:0] r;
        logic [POS_W-1:0]  q;
        r = rem_reg;
        q = shift_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial = {r, q[POS_W-1]};
            q     = {q[POS_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            r = trial[FLEN_W-1:0];
        end
        rem_next   = r;
        shift_next = q;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (step)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign remainder = rem_reg;

endmodule

FILE: rtl/shrb_ctrl.sv
// Controller state machine sequencing stores and replay reads.
`include "sample_history_ring_buffer_top_assert.svh"

module shrb_ctrl import shrb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (status.op == OP_READ))
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:   state_next = ST_OFFS;
            ST_OFFS:   state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_DATA;
            ST_DATA:   state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                cmd.store  = s_tvalid && (status.op == OP_STORE);
            end
            ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                cmd.div_step  = 1'b1;
            end
            ST_OFFS:
            begin
                cmd.calc_offs = 1'b1;
                cmd.div_step  = 1'b1;
            end
            ST_ADDR:
            begin
                cmd.rd_en    = 1'b1;
                cmd.div_step = 1'b1;
            end
            ST_DATA:
            begin
                cmd.div_step = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A read request starts the sequence; a finished result waits for a free output.
    `SHRB_ASSERT_NEXT(a_read_starts, cmd.accept && (status.op == OP_READ), state_reg == ST_DIFF)
    `SHRB_ASSERT_NEXT(a_result_waits, (state_reg == ST_RESULT) && !status.out_free,
                      state_reg == ST_RESULT)

endmodule

FILE: rtl/shrb_datapath.sv
// Datapath: pointers, fill count, sample memory, offset and frame arithmetic, output register.
`include "sample_history_ring_buffer_top_assert.svh"

module shrb_datapath import shrb_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic [FLEN_W-1:0]      frame_length,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int SBX = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [AW:0] CAP_W = (AW + 1)'(CAPACITY);
    localparam logic [AW:0] CAP_M1 = (AW + 1)'(CAPACITY - 1);

    // Input fields.
    logic [SAMPLE_W-1:0] in_sample;
    logic [TIME_W-1:0]   in_sample_time;
    logic [TIME_W-1:0]   in_start_time;
    logic [POS_W-1:0]    in_read_position;

    assign in_sample        = s_tdata[SAMPLE_W-1:0];
    assign in_sample_time   = s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
    assign in_start_time    = s_tdata[SAMPLE_W+2*TIME_W-1:SAMPLE_W+TIME_W];
    assign in_read_position = s_tdata[IN_TDATA_W-1:SAMPLE_W+2*TIME_W];

    // History state.
    logic [AW-1:0]     wp_reg;
    logic [AW:0]       fill_count_reg;
    logic [TIME_W-1:0] newest_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            fill_count_reg <= '0;
            newest_end_reg <= '0;
        end
        else if (cmd.store)
        begin
            wp_reg <= ({1'b0, wp_reg} == CAP_M1) ? '0 : wp_reg + AW'(1);
            if (fill_count_reg != CAP_W)
            begin
                fill_count_reg <= fill_count_reg + (AW + 1)'(1);
            end
            newest_end_reg <= in_sample_time + TIME_W'(1);
        end
    end

    // Sample memory.
    logic [SBX-1:0]         wr_ext;
    logic [SBX-1:0]         rd_ext;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [AW-1:0]          rd_addr;

    assign wr_ext    = SBX'(in_sample);
    assign ram_wdata = wr_ext[SAMPLE_BITS-1:0];
    assign rd_ext    = SBX'(ram_rdata);

    shrb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (wp_reg),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Read request arithmetic.
    logic [TIME_W-1:0]   start_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [DIFF_W-2:0]   diff_reg;
    logic [DIFF_W-1:0]   offset_reg;
    logic [AW-1:0]       base_reg;
    logic                avail_reg;
    logic                last_hist_reg;
    logic [DIFF_W-1:0]   diff_full;
    logic [DIFF_W-1:0]   fill_wide;
    logic [AW:0]         wp_ext;
    logic [AW:0]         base_full;
    logic [AW:0]         idx_sum;
    logic [AW:0]         idx_wrap;

    assign fill_wide = DIFF_W'(fill_count_reg);
    // Offset from the oldest sample: start - (newest_end - fill), exact.
    assign diff_full = {2'b00, start_reg} - {2'b00, newest_end_reg} + fill_wide;

    assign wp_ext    = {1'b0, wp_reg};
    assign base_full = (wp_ext >= fill_count_reg) ? (wp_ext - fill_count_reg)
                                                  : (wp_ext + CAP_W - fill_count_reg);

    assign idx_sum  = {1'b0, base_reg} + {1'b0, offset_reg[AW-1:0]};
    assign idx_wrap = idx_sum - CAP_W;
    assign rd_addr  = (idx_sum >= CAP_W) ? idx_wrap[AW-1:0] : idx_sum[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            start_reg <= in_start_time;
            pos_reg   <= in_read_position;
        end
        if (cmd.calc_diff)
        begin
            diff_reg <= diff_full[DIFF_W-1] ? '0 : diff_full[DIFF_W-2:0];
        end
        if (cmd.calc_offs)
        begin
            offset_reg <= {1'b0, diff_reg} + DIFF_W'(pos_reg);
            base_reg   <= base_full[AW-1:0];
        end
        if (cmd.rd_en)
        begin
            avail_reg     <= offset_reg < fill_wide;
            last_hist_reg <= (offset_reg + DIFF_W'(1)) == fill_wide;
        end
    end

    // Frame arithmetic.
    logic [FLEN_W-1:0] flen_eff;
    logic [FLEN_W-1:0] frame_rem;
    logic              frame_last;
    logic [POS_W-1:0]  frame_first;

    assign flen_eff = (frame_length == '0) ? FLEN_W'(1) : frame_length;

    shrb_frame_div u_div (
        .clk       (clk),
        .start     (cmd.accept),
        .step      (cmd.div_step),
        .dividend  (in_read_position),
        .divisor   (flen_eff),
        .remainder (frame_rem)
    );

    assign frame_last  = (frame_rem == (flen_eff - FLEN_W'(1))) || last_hist_reg;
    assign frame_first = pos_reg - POS_W'(frame_rem);

    // Output register.
    logic                   m_tvalid_reg;
    logic [SAMPLE_W-1:0]    out_sample_reg;
    logic [POS_W-1:0]       out_start_reg;
    logic                   out_avail_reg;
    logic                   out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_avail_reg  <= avail_reg;
            out_sample_reg <= avail_reg ? rd_ext[SAMPLE_W-1:0] : '0;
            out_last_reg   <= avail_reg && frame_last;
            out_start_reg  <= avail_reg ? frame_first : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_start_reg, out_sample_reg};
    assign m_tuser  = out_avail_reg;
    assign m_tlast  = out_last_reg;

    assign status.op       = s_tuser;
    assign status.out_free = !m_tvalid_reg || m_tready;

    // Until the history is full the write pointer equals the fill count.
    `SHRB_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_reg <= CAP_W)
    `SHRB_ASSERT_NOW(a_wp_tracks_fill, fill_count_reg != CAP_W, wp_ext == fill_count_reg)
    `SHRB_ASSERT_NEXT(a_fill_grows, cmd.store && (fill_count_reg != CAP_W),
                      fill_count_reg == ($past(fill_count_reg) + (AW + 1)'(1)))

endmodule

FILE: rtl/sample_history_ring_buffer_top.sv
// Store request: written to memory on acceptance, one store per cycle while idle; no result.
// Read request: states DIFF, OFFS, ADDR and DATA compute the offset, issue the registered
// memory read and step the frame remainder unit (four quotient bits a cycle); RESULT loads
// the output register once it is free, and only then is the next request accepted.
// Reset clears write pointer, fill count and end time and sets frame_length to 1024;
// the sample memory is not cleared, so the block is ready straight after reset.
module sample_history_ring_buffer_top import shrb_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: sample[31:0], sample_time[79:32], start_time[127:80],
    //          read_position[143:128]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: op[0]
    input  logic                   s_tuser,
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: replay_sample[31:0], frame_start[47:32]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: available[0]
    output logic                   m_tuser,
    // m_tlast: frame_end
    output logic                   m_tlast,
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [FLEN_W-1:0] frame_length_reg;
    logic              cfg_write;
    logic              reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FLEN_RESET;
        end
        else if (cfg_write && (reg_index == REG_FRAME_LENGTH))
        begin
            frame_length_reg <= pwdata[FLEN_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_FRAME_LENGTH: prdata = APB_DATA_W'(frame_length_reg);
            default:          prdata = '0;
        endcase
    end

    ctrl_cmd_t  cmd;
    dp_status_t status;

    shrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    shrb_datapath #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .frame_length (frame_length_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
